// ===== rtl/core/script_token_lexer_macros.svh =====
// Assertion macros shared by the lexer RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SCRIPT_TOKEN_LEXER_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define STL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define STL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define STL_ASSERT_IMP(lbl, ante, cons, msg)
`define STL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/stl_pkg.sv =====
package stl_pkg;

	localparam int POS_BITS_DEF = 16;

	// Result queue geometry.
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = 3;
	localparam int OQ_CW    = 4;
	localparam int EMIT_MAX = 3;

	localparam logic [6:0]  KW_ALL  = 7'h7F;
	localparam int          KW_NUM  = 7;
	localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;
	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	localparam logic [4:0] KIND_EQEQ   = 5'd7;
	localparam logic [4:0] KIND_NEQ    = 5'd8;
	localparam logic [4:0] KIND_PLUS   = 5'd9;
	localparam logic [4:0] KIND_MINUS  = 5'd10;
	localparam logic [4:0] KIND_STAR   = 5'd11;
	localparam logic [4:0] KIND_SLASH  = 5'd12;
	localparam logic [4:0] KIND_COMMA  = 5'd13;
	localparam logic [4:0] KIND_LPAREN = 5'd14;
	localparam logic [4:0] KIND_RPAREN = 5'd15;
	localparam logic [4:0] KIND_LBRACE = 5'd16;
	localparam logic [4:0] KIND_RBRACE = 5'd17;
	localparam logic [4:0] KIND_ASSIGN = 5'd18;
	localparam logic [4:0] KIND_DOT    = 5'd19;
	localparam logic [4:0] KIND_LT     = 5'd20;
	localparam logic [4:0] KIND_GT     = 5'd21;
	localparam logic [4:0] KIND_SEMI   = 5'd22;
	localparam logic [4:0] KIND_ATTR   = 5'd23;
	localparam logic [4:0] KIND_INT    = 5'd24;
	localparam logic [4:0] KIND_NAME   = 5'd25;
	localparam logic [4:0] KIND_STR    = 5'd26;
	localparam logic [4:0] KIND_END    = 5'd27;
	localparam logic [4:0] KIND_ERR    = 5'd28;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NAME,
		MODE_INT,
		MODE_ATTR,
		MODE_STR,
		MODE_EQ,
		MODE_BANG
	} mode_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [30:0] int_value;
		logic        overflow;
		logic [15:0] start_pos;
		logic [15:0] tok_len;
		logic        last_of_run;
	} tok_t;

	typedef struct packed {
		logic vld;
		tok_t tok;
	} emit_t;

	// Tokens produced by one text byte, in order, cnt of them valid.
	typedef struct packed {
		logic [1:0]      cnt;
		tok_t [2:0]      tok;
	} burst_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_namech(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == "_";
	endfunction

	function automatic logic [15:0] len_inc(input logic [15:0] l);
		return (l == LEN_MAX) ? l : l + 16'd1;
	endfunction

	function automatic logic [2:0] kw_len(input logic [2:0] k);
		logic [2:0] r;
		case (k)
			3'd0: r = 3'd6;
			3'd1: r = 3'd3;
			3'd2: r = 3'd4;
			3'd3: r = 3'd5;
			3'd4: r = 3'd5;
			3'd5: r = 3'd3;
			3'd6: r = 3'd3;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
		logic [47:0] s;
		case (k)
			3'd0: s = "return";
			3'd1: s = {"nil", 24'd0};
			3'd2: s = {"true", 16'd0};
			3'd3: s = {"false", 8'd0};
			3'd4: s = {"class", 8'd0};
			3'd5: s = {"def", 24'd0};
			3'd6: s = {"end", 24'd0};
			default: s = '0;
		endcase
		if (i > 3'd5)
			return 8'd0;
		return s[47 - 8 * i -: 8];
	endfunction

	// Drop every keyword whose next character does not match c.
	function automatic logic [6:0] kw_filter(input logic [6:0] kw, input logic [15:0] len,
		input logic [7:0] c);
		logic [6:0] r;
		r = kw;
		for (int k = 0; k < KW_NUM; k++) begin
			if (!(kw[k] && len < 16'(kw_len(3'(k))) && kw_char(3'(k), len[2:0]) == c))
				r[k] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [4:0] single_kind(input logic [7:0] c);
		logic [4:0] r;
		case (c)
			"+": r = KIND_PLUS;
			"-": r = KIND_MINUS;
			"*": r = KIND_STAR;
			"/": r = KIND_SLASH;
			",": r = KIND_COMMA;
			"(": r = KIND_LPAREN;
			")": r = KIND_RPAREN;
			"{": r = KIND_LBRACE;
			"}": r = KIND_RBRACE;
			".": r = KIND_DOT;
			"<": r = KIND_LT;
			">": r = KIND_GT;
			";": r = KIND_SEMI;
			default: r = KIND_ERR;
		endcase
		return r;
	endfunction

	function automatic tok_t mk_tok(input logic [4:0] kind, input logic [15:0] start,
		input logic [15:0] len);
		tok_t t;
		t = '0;
		t.kind = kind;
		t.start_pos = start;
		t.tok_len = len;
		return t;
	endfunction

	function automatic burst_t add_tok(input burst_t b, input tok_t t);
		burst_t r;
		r = b;
		r.tok[r.cnt] = t;
		r.cnt = r.cnt + 2'd1;
		return r;
	endfunction

	// Token that closes the open scan; a string only closes (as an error) at end of text.
	function automatic emit_t close_tok(input mode_t m, input logic [6:0] kw,
		input logic [15:0] start, input logic [15:0] err_start, input logic [15:0] len,
		input logic [30:0] acc, input logic ovf, input logic at_end);
		emit_t e;
		logic [4:0] kind;
		logic found;
		e = '0;
		kind = KIND_NAME;
		found = 1'b0;
		case (m)
			MODE_NAME: begin
				for (int k = 0; k < KW_NUM; k++) begin
					if (!found && kw[k] && len == 16'(kw_len(3'(k)))) begin
						kind = 5'(k);
						found = 1'b1;
					end
				end
				e.vld = 1'b1;
				e.tok = mk_tok(kind, start, len);
			end
			MODE_INT: begin
				e.vld = 1'b1;
				e.tok = mk_tok(KIND_INT, start, len);
				e.tok.int_value = acc;
				e.tok.overflow = ovf;
			end
			MODE_ATTR: begin
				e.vld = 1'b1;
				e.tok = mk_tok(KIND_ATTR, start, len);
			end
			MODE_EQ: begin
				e.vld = 1'b1;
				e.tok = mk_tok(KIND_ASSIGN, start, 16'd1);
			end
			MODE_BANG: begin
				e.vld = 1'b1;
				e.tok = mk_tok(KIND_ERR, start, 16'd1);
			end
			MODE_STR: begin
				e.vld = at_end;
				e.tok = mk_tok(KIND_ERR, err_start, len_inc(len));
			end
			default: begin
			end
		endcase
		return e;
	endfunction

endpackage

// ===== rtl/core/stl_scan.sv =====
`include "script_token_lexer_macros.svh"

module stl_scan import stl_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] ch,
	input  logic       last,
	output burst_t     burst
);

	mode_t                mode_q, mode_d;
	logic [6:0]           kw_q, kw_d;
	logic                 delim_q, delim_d;
	logic [30:0]          acc_q, acc_d;
	logic                 ovf_q, ovf_d;
	logic [POS_BITS-1:0]  pos_q, pos_d;
	logic [POS_BITS-1:0]  tstart_q, tstart_d;
	logic [15:0]          tlen_q, tlen_d;

	logic                 handled;
	logic                 text_end;
	logic [POS_BITS-1:0]  endpos;
	logic [34:0]          prod;
	emit_t                e_mid, e_end;
	burst_t               bst;

	function automatic logic [15:0] to16(input logic [POS_BITS-1:0] p);
		logic [POS_BITS+15:0] x;
		x = {16'd0, p};
		return x[15:0];
	endfunction

	assign text_end = (ch == 8'd0) || last;
	assign endpos = (ch == 8'd0) ? pos_q : pos_q + POS_BITS'(1);
	// acc * 10 + digit, as shifts and adds.
	assign prod = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + 35'(ch[3:0]);

	always_comb begin
		mode_d = mode_q;
		kw_d = kw_q;
		delim_d = delim_q;
		acc_d = acc_q;
		ovf_d = ovf_q;
		pos_d = pos_q;
		tstart_d = tstart_q;
		tlen_d = tlen_q;
		bst = '0;
		handled = 1'b0;
		e_mid = '0;
		e_end = '0;

		if (step && ch != 8'd0) begin
			case (mode_q)
				MODE_STR: begin
					handled = 1'b1;
					if (ch == (delim_q ? 8'("'") : 8'("\""))) begin
						bst = add_tok(bst, mk_tok(KIND_STR, to16(tstart_q), tlen_q));
						mode_d = MODE_IDLE;
					end else begin
						tlen_d = len_inc(tlen_q);
					end
				end
				MODE_NAME: begin
					if (is_namech(ch)) begin
						handled = 1'b1;
						kw_d = kw_filter(kw_q, tlen_q, ch);
						tlen_d = len_inc(tlen_q);
					end
				end
				MODE_ATTR: begin
					if (is_namech(ch)) begin
						handled = 1'b1;
						tlen_d = len_inc(tlen_q);
					end
				end
				MODE_INT: begin
					if (is_digit(ch)) begin
						handled = 1'b1;
						if (prod > {4'd0, INT_MAX}) begin
							acc_d = INT_MAX;
							ovf_d = 1'b1;
						end else begin
							acc_d = prod[30:0];
						end
						tlen_d = len_inc(tlen_q);
					end
				end
				MODE_EQ, MODE_BANG: begin
					if (ch == "=") begin
						handled = 1'b1;
						bst = add_tok(bst, mk_tok((mode_q == MODE_EQ) ? KIND_EQEQ : KIND_NEQ,
							to16(tstart_q), 16'd2));
						mode_d = MODE_IDLE;
					end
				end
				default: begin
				end
			endcase

			if (!handled) begin
				// The byte cannot extend the open token: close it, then start afresh.
				e_mid = close_tok(mode_q, kw_q, to16(tstart_q), to16(tstart_q - POS_BITS'(1)),
					tlen_q, acc_q, ovf_q, 1'b0);
				if (e_mid.vld)
					bst = add_tok(bst, e_mid.tok);
				mode_d = MODE_IDLE;
				if (is_ws(ch)) begin
				end else if (is_alpha(ch)) begin
					mode_d = MODE_NAME;
					tstart_d = pos_q;
					tlen_d = 16'd1;
					kw_d = kw_filter(KW_ALL, 16'd0, ch);
				end else if (is_digit(ch)) begin
					mode_d = MODE_INT;
					tstart_d = pos_q;
					tlen_d = 16'd1;
					acc_d = 31'(ch[3:0]);
					ovf_d = 1'b0;
				end else if (ch == "@") begin
					mode_d = MODE_ATTR;
					tstart_d = pos_q + POS_BITS'(1);
					tlen_d = 16'd0;
				end else if (ch == "\"" || ch == "'") begin
					mode_d = MODE_STR;
					tstart_d = pos_q + POS_BITS'(1);
					tlen_d = 16'd0;
					delim_d = (ch == "'");
				end else if (ch == "=") begin
					mode_d = MODE_EQ;
					tstart_d = pos_q;
					tlen_d = 16'd0;
				end else if (ch == "!") begin
					mode_d = MODE_BANG;
					tstart_d = pos_q;
					tlen_d = 16'd0;
				end else begin
					bst = add_tok(bst, mk_tok(single_kind(ch), to16(pos_q), 16'd1));
				end
			end
		end

		if (step && text_end) begin
			e_end = close_tok(mode_d, kw_d, to16(tstart_d), to16(tstart_d - POS_BITS'(1)),
				tlen_d, acc_d, ovf_d, 1'b1);
			if (e_end.vld)
				bst = add_tok(bst, e_end.tok);
			bst = add_tok(bst, mk_tok(KIND_END, to16(endpos), 16'd0));
			mode_d = MODE_IDLE;
			kw_d = KW_ALL;
			delim_d = 1'b0;
			acc_d = '0;
			ovf_d = 1'b0;
			pos_d = '0;
			tstart_d = '0;
			tlen_d = '0;
		end else if (step) begin
			pos_d = endpos;
		end

		if (bst.cnt != 2'd0)
			bst.tok[bst.cnt - 2'd1].last_of_run = 1'b1;
	end

	assign burst = bst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			kw_q <= KW_ALL;
			delim_q <= 1'b0;
			acc_q <= '0;
			ovf_q <= 1'b0;
			pos_q <= '0;
			tstart_q <= '0;
			tlen_q <= '0;
		end else begin
			mode_q <= mode_d;
			kw_q <= kw_d;
			delim_q <= delim_d;
			acc_q <= acc_d;
			ovf_q <= ovf_d;
			pos_q <= pos_d;
			tstart_q <= tstart_d;
			tlen_q <= tlen_d;
		end
	end

	`STL_ASSERT_NXT(a_end_restarts, step && text_end, mode_q == MODE_IDLE && pos_q == '0, "text end did not restart the scanner")
	`STL_ASSERT_IMP(a_end_emits, step && text_end, burst.cnt != 2'd0 && burst.tok[burst.cnt - 2'd1].kind == KIND_END, "text end without end token")
	`STL_ASSERT_NXT(a_pos_advance, step && !text_end, pos_q == $past(pos_q) + POS_BITS'(1), "byte position did not advance")

endmodule

// ===== rtl/core/stl_outq.sv =====
`include "script_token_lexer_macros.svh"

module stl_outq import stl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  burst_t burst,
	input  logic   pop,
	output tok_t   head,
	output logic   nonempty,
	output logic   room
);

	tok_t             mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_CW-1:0] count_q;
	logic [1:0]       push_n;

	assign push_n = push ? burst.cnt : 2'd0;
	assign nonempty = (count_q != '0);
	// Room for the largest burst one byte can produce.
	assign room = (count_q <= OQ_CW'(OQ_DEPTH - EMIT_MAX));
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < EMIT_MAX; i++) begin
			if (2'(i) < push_n)
				mem_q[wr_ptr_q + OQ_AW'(i)] <= burst.tok[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_AW'(push_n);
			rd_ptr_q <= rd_ptr_q + OQ_AW'(pop);
			count_q <= count_q + OQ_CW'(push_n) - OQ_CW'(pop);
		end
	end

	`STL_ASSERT_IMP(a_push_has_room, push, room, "token burst written without room")
	`STL_ASSERT_IMP(a_pop_nonempty, pop, count_q != '0, "read from empty token queue")
	`STL_ASSERT_IMP(a_ptr_count, 1'b1, OQ_AW'(wr_ptr_q - rd_ptr_q) == count_q[OQ_AW-1:0], "queue pointers disagree with count")

endmodule

// ===== rtl/core/script_token_lexer.sv =====
// Streaming lexer: one text byte per transaction on the input side, one token per transaction
// on the output side. A byte is registered, lexed combinationally (0 to 3 tokens, e.g. a
// closing name, an operator and the end token), and the tokens are written into an 8-entry
// result queue, whose head offers them; a registered byte waits while the queue lacks room.
// Input is taken every cycle while the queue has at least three free entries, so the block
// sustains one byte per cycle as long as the consumer takes tokens as fast as they appear;
// the one-token-per-cycle read port of the queue sets the rate when bytes produce more tokens.
// A zero byte or a byte flagged last ends the text with an end token and restarts offsets at
// zero. Tokens carry kind, start offset and length; integers also carry a saturated value.
// There is no start-up sequence: the block is ready for bytes straight out of reset.
module script_token_lexer import stl_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic [30:0] int_value,
	output logic        overflow,
	output logic [15:0] start_pos,
	output logic [15:0] tok_len,
	output logic        last_of_run
);

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       advance;
	logic       room;
	logic       pop;
	burst_t     burst;
	tok_t       head;

	assign advance = valid_s1 && room;
	assign in_ready = !valid_s1 || advance;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1 <= ch;
			last_s1 <= last;
		end
	end

	stl_scan #(
		.POS_BITS(POS_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.ch     (ch_s1),
		.last   (last_s1),
		.burst  (burst)
	);

	stl_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance),
		.burst    (burst),
		.pop      (pop),
		.head     (head),
		.nonempty (out_valid),
		.room     (room)
	);

	assign token_kind = head.kind;
	assign int_value = head.int_value;
	assign overflow = head.overflow;
	assign start_pos = head.start_pos;
	assign tok_len = head.tok_len;
	assign last_of_run = head.last_of_run;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import stl_pkg::*;

	localparam int CLK_HIGH = 6;
	localparam int CLK_LOW = 6;
	localparam int RESET_CYCLES = 10;
	localparam int CYCLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_BYTES = 200;
	localparam int HOLD_CYCLES = 200;
	localparam int IDLE_PCT = 22;
	localparam int QUIET_FIRST = 2;
	localparam int QUIET_LAST = 3;
	localparam int HOLD_TEXT = 5;
	localparam int PAUSE_TEXT = 4;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  ch;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [4:0]  token_kind;
	logic [30:0] int_value;
	logic        overflow;
	logic [15:0] start_pos;
	logic [15:0] tok_len;
	logic        last_of_run;

	// Predicts the token stream of the lexer and checks the tokens that come out.
	class token_scoreboard;
		// Keyword kinds follow the order of kw_words.
		localparam logic [4:0] KIND_KW_FIRST = 5'd0;

		tok_t        expected_tokens[$];
		tok_t        burst[$];
		int          errors;
		string       kw_words[7];
		mode_t       scan_mode;
		logic [6:0]  kw_live;
		logic        quote_single;
		logic [30:0] int_acc;
		logic        int_sat;
		logic [15:0] byte_pos;
		logic [15:0] tok_start;
		logic [15:0] tok_length;

		function new();
			kw_words = '{"return", "nil", "true", "false", "class", "def", "end"};
			errors = 0;
			clear_state();
		endfunction

		function void clear_state();
			scan_mode = MODE_IDLE;
			kw_live = KW_ALL;
			quote_single = 1'b0;
			int_acc = '0;
			int_sat = 1'b0;
			byte_pos = '0;
			tok_start = '0;
			tok_length = '0;
		endfunction

		function int outstanding();
			return expected_tokens.size();
		endfunction

		function bit is_letter(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit is_num(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit is_space(logic [7:0] c);
			return c == " " || (c >= 8'd9 && c <= 8'd13);
		endfunction

		function bit is_word_char(logic [7:0] c);
			return is_letter(c) || is_num(c) || c == "_";
		endfunction

		function void add_token(logic [4:0] kind, logic [30:0] value, logic sat,
			logic [15:0] start, logic [15:0] len);
			tok_t t;
			t = '0;
			t.kind = kind;
			t.int_value = value;
			t.overflow = sat;
			t.start_pos = start;
			t.tok_len = len;
			burst.push_back(t);
		endfunction

		function void bump_length();
			if (tok_length != LEN_MAX)
				tok_length = tok_length + 16'd1;
		endfunction

		function void narrow_keywords(logic [7:0] c);
			for (int k = 0; k < KW_NUM; k++) begin
				if (kw_live[k]) begin
					if (tok_length >= kw_words[k].len())
						kw_live[k] = 1'b0;
					else if (kw_words[k][tok_length] != c)
						kw_live[k] = 1'b0;
				end
			end
		endfunction

		function void start_scan(mode_t m, logic [15:0] start);
			scan_mode = m;
			tok_start = start;
			tok_length = '0;
		endfunction

		function logic [4:0] punct_kind(logic [7:0] c);
			case (c)
				"+": return KIND_PLUS;
				"-": return KIND_MINUS;
				"*": return KIND_STAR;
				"/": return KIND_SLASH;
				",": return KIND_COMMA;
				"(": return KIND_LPAREN;
				")": return KIND_RPAREN;
				"{": return KIND_LBRACE;
				"}": return KIND_RBRACE;
				".": return KIND_DOT;
				"<": return KIND_LT;
				">": return KIND_GT;
				";": return KIND_SEMI;
				default: return KIND_ERR;
			endcase
		endfunction

		// An open string only closes here, as an error, when the text ends.
		function void close_open(bit at_end);
			logic [4:0] kind;
			bit found;
			case (scan_mode)
				MODE_NAME: begin
					kind = KIND_NAME;
					found = 1'b0;
					for (int k = 0; k < KW_NUM; k++) begin
						if (!found && kw_live[k] && tok_length == kw_words[k].len()) begin
							kind = KIND_KW_FIRST + 5'(k);
							found = 1'b1;
						end
					end
					add_token(kind, '0, 1'b0, tok_start, tok_length);
				end
				MODE_INT: add_token(KIND_INT, int_acc, int_sat, tok_start, tok_length);
				MODE_ATTR: add_token(KIND_ATTR, '0, 1'b0, tok_start, tok_length);
				MODE_EQ: add_token(KIND_ASSIGN, '0, 1'b0, tok_start, 16'd1);
				MODE_BANG: add_token(KIND_ERR, '0, 1'b0, tok_start, 16'd1);
				MODE_STR: begin
					if (!at_end)
						return;
					add_token(KIND_ERR, '0, 1'b0, tok_start - 16'd1,
						(tok_length == LEN_MAX) ? LEN_MAX : tok_length + 16'd1);
				end
				default: begin
				end
			endcase
			scan_mode = MODE_IDLE;
		endfunction

		function void idle_byte(logic [7:0] c);
			if (is_space(c))
				return;
			if (is_letter(c)) begin
				start_scan(MODE_NAME, byte_pos);
				kw_live = KW_ALL;
				narrow_keywords(c);
				bump_length();
			end else if (is_num(c)) begin
				start_scan(MODE_INT, byte_pos);
				int_acc = 31'(c - "0");
				int_sat = 1'b0;
				bump_length();
			end else if (c == "@") begin
				start_scan(MODE_ATTR, byte_pos + 16'd1);
			end else if (c == "\"" || c == "'") begin
				start_scan(MODE_STR, byte_pos + 16'd1);
				quote_single = (c == "'");
			end else if (c == "=") begin
				start_scan(MODE_EQ, byte_pos);
			end else if (c == "!") begin
				start_scan(MODE_BANG, byte_pos);
			end else begin
				add_token(punct_kind(c), '0, 1'b0, byte_pos, 16'd1);
			end
		endfunction

		function void scan_byte(logic [7:0] c);
			longint unsigned v;
			case (scan_mode)
				MODE_STR: begin
					if (c == (quote_single ? "'" : "\"")) begin
						add_token(KIND_STR, '0, 1'b0, tok_start, tok_length);
						scan_mode = MODE_IDLE;
					end else begin
						bump_length();
					end
					return;
				end
				MODE_NAME: begin
					if (is_word_char(c)) begin
						narrow_keywords(c);
						bump_length();
						return;
					end
				end
				MODE_ATTR: begin
					if (is_word_char(c)) begin
						bump_length();
						return;
					end
				end
				MODE_INT: begin
					if (is_num(c)) begin
						v = int_acc;
						v = v * 10 + (c - "0");
						if (v > INT_MAX) begin
							int_acc = INT_MAX;
							int_sat = 1'b1;
						end else begin
							int_acc = 31'(v);
						end
						bump_length();
						return;
					end
				end
				MODE_EQ, MODE_BANG: begin
					if (c == "=") begin
						add_token((scan_mode == MODE_EQ) ? KIND_EQEQ : KIND_NEQ, '0, 1'b0,
							tok_start, 16'd2);
						scan_mode = MODE_IDLE;
						return;
					end
				end
				default: begin
				end
			endcase
			close_open(1'b0);
			idle_byte(c);
		endfunction

		function void note_byte(logic [7:0] c, logic is_last);
			logic [15:0] end_pos;
			burst.delete();
			if (c == 8'd0) begin
				end_pos = byte_pos;
			end else begin
				scan_byte(c);
				end_pos = byte_pos + 16'd1;
			end
			if (c == 8'd0 || is_last) begin
				close_open(1'b1);
				add_token(KIND_END, '0, 1'b0, end_pos, 16'd0);
				clear_state();
			end else begin
				byte_pos = end_pos;
			end
			if (burst.size() > 0)
				burst[burst.size() - 1].last_of_run = 1'b1;
			foreach (burst[i])
				expected_tokens.push_back(burst[i]);
		endfunction

		function void compare_field(string label, logic [30:0] want_v, logic [30:0] got_v);
			if (want_v !== got_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v,
					got_v);
				errors++;
			end
		endfunction

		function void check_token(logic [4:0] kind, logic [30:0] value, logic sat,
			logic [15:0] start, logic [15:0] len, logic final_flag);
			tok_t want;
			if (expected_tokens.size() == 0) begin
				$display("%0t: unexpected token, expected none, actual kind %0d start %0d len %0d",
					$time, kind, start, len);
				errors++;
				return;
			end
			want = expected_tokens.pop_front();
			compare_field("token_kind", 31'(want.kind), 31'(kind));
			compare_field("int_value", want.int_value, value);
			compare_field("overflow", 31'(want.overflow), 31'(sat));
			compare_field("start_pos", 31'(want.start_pos), 31'(start));
			compare_field("tok_len", 31'(want.tok_len), 31'(len));
			compare_field("last_of_run", 31'(want.last_of_run), 31'(final_flag));
		endfunction
	endclass

	token_scoreboard tokens;
	logic [7:0]      text_bytes[$];
	int              tx_idle_pct;
	int              rx_idle_pct;
	bit              hold_req;
	int              cycle_count;

	script_token_lexer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.int_value(int_value),
		.overflow(overflow),
		.start_pos(start_pos),
		.tok_len(tok_len),
		.last_of_run(last_of_run)
	);

	always begin
		clk = 1'b0;
		#CLK_LOW;
		clk = 1'b1;
		#CLK_HIGH;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (out_valid && out_ready)
				tokens.check_token(token_kind, int_value, overflow, start_pos, tok_len,
					last_of_run);
			if (in_valid && in_ready)
				tokens.note_byte(ch, last);
			if (cycle_count > CYCLE_LIMIT) begin
				$display("%0t: timeout after %0d cycles", $time, cycle_count);
				$display("script_token_lexer regression: fail");
				$finish;
			end
		end
	end

	// Token sink; a hold request stalls it long enough for the block to back up.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++)
			text_bytes.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return 8'("a" + $urandom_range(0, 25));
		return 8'("A" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_word_char();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return rand_letter();
		if (pick < 9)
			return 8'("0" + $urandom_range(0, 9));
		return "_";
	endfunction

	function automatic void add_random_token();
		int pick;
		int n;
		logic [7:0] q;
		string kw;
		string ops;
		pick = $urandom_range(0, 99);
		ops = "+-*/,(){}.<>;";
		kw = tokens.kw_words[$urandom_range(0, KW_NUM - 1)];
		if (pick < 12) begin
			add_str(kw);
		end else if (pick < 17) begin
			// Near misses: a keyword with an extra tail or cut short.
			if ($urandom_range(0, 1)) begin
				add_str(kw);
				text_bytes.push_back(rand_word_char());
			end else begin
				add_str(kw.substr(0, kw.len() - 2));
			end
		end else if (pick < 32) begin
			text_bytes.push_back(rand_letter());
			n = $urandom_range(0, 8);
			repeat (n) text_bytes.push_back(rand_word_char());
		end else if (pick < 44) begin
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 15) : $urandom_range(1, 6);
			repeat (n) text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
		end else if (pick < 58) begin
			text_bytes.push_back(ops[$urandom_range(0, ops.len() - 1)]);
		end else if (pick < 64) begin
			case ($urandom_range(0, 3))
				0: add_str("==");
				1: add_str("!=");
				2: add_str("=");
				default: add_str("!");
			endcase
		end else if (pick < 70) begin
			text_bytes.push_back("@");
			n = $urandom_range(0, 5);
			repeat (n) text_bytes.push_back(rand_word_char());
		end else if (pick < 80) begin
			q = $urandom_range(0, 1) ? "'" : "\"";
			text_bytes.push_back(q);
			n = $urandom_range(0, 10);
			repeat (n) text_bytes.push_back(8'($urandom_range(1, 255)));
			if ($urandom_range(0, 9) != 0)
				text_bytes.push_back(q);
		end else if (pick < 88) begin
			text_bytes.push_back(($urandom_range(0, 5) == 0) ? 8'd32 : 8'($urandom_range(9, 13)));
		end else begin
			text_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 9) < 6)
			text_bytes.push_back(" ");
	endfunction

	task automatic send_byte(logic [7:0] c, logic flag);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		last <= flag;
		do @(posedge clk); while (!in_ready);
	endtask

	// A text ends either with the last flag on its final byte or with a zero byte.
	task automatic send_text(bit use_last);
		if (!use_last || text_bytes.size() == 0)
			text_bytes.push_back(8'd0);
		foreach (text_bytes[i])
			send_byte(text_bytes[i], use_last && i == text_bytes.size() - 1);
		text_bytes.delete();
	endtask

	task automatic wait_tokens_done();
		in_valid <= 1'b0;
		do @(posedge clk); while (tokens.outstanding() != 0);
	endtask

	initial begin
		int sent;
		int text_no;
		int n;
		tokens = new();
		text_bytes.delete();
		tx_idle_pct = IDLE_PCT;
		rx_idle_pct = IDLE_PCT;
		hold_req = 1'b0;
		cycle_count = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = 8'd0;
		last = 1'b0;
		out_ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		add_str("return nil true false class def end");
		send_text(1'b1);
		add_str("== != = ! @attr @ 'a' \"b\" 12 +-*/,(){}.<>; _x ");
		text_bytes.push_back(8'd128);
		text_bytes.push_back(8'd255);
		for (int w = 9; w <= 13; w++)
			text_bytes.push_back(8'(w));
		send_text(1'b0);
		add_str("2147483647 2147483648 99999999999;");
		send_text(1'b0);
		add_str("x!y a=b returns ret nil_ Nil 12ab");
		send_text(1'b0);
		add_str("\"abc");
		send_text(1'b1);
		add_str("'q");
		send_text(1'b0);
		// A name closed by an operator on the last byte gives three tokens at once.
		add_str("ab+");
		send_text(1'b1);
		add_str("=");
		send_text(1'b1);
		add_str("!");
		send_text(1'b1);
		add_str("@");
		send_text(1'b1);
		send_text(1'b0);

		sent = 0;
		text_no = 0;
		while (sent < RANDOM_BYTES) begin
			text_no++;
			if (text_no == QUIET_FIRST) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (text_no == QUIET_LAST + 1) begin
				tx_idle_pct = IDLE_PCT;
				rx_idle_pct = IDLE_PCT;
			end
			if (text_no == HOLD_TEXT)
				hold_req = 1'b1;
			if (text_no == PAUSE_TEXT)
				wait_tokens_done();
			n = (text_no == HOLD_TEXT) ? 30 : $urandom_range(1, 10);
			repeat (n) add_random_token();
			sent += text_bytes.size();
			send_text($urandom_range(0, 1));
		end

		wait_tokens_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tokens.outstanding() != 0)
			$display("%0t: %0d expected tokens never arrived", $time, tokens.outstanding());
		if (tokens.errors == 0 && tokens.outstanding() == 0) begin
			$display("script_token_lexer regression: pass");
		end else begin
			$display("script_token_lexer regression: fail");
		end
		$finish;
	end

endmodule

// ===== script_token_lexer.f =====
+incdir+rtl/core
rtl/core/stl_pkg.sv
rtl/core/stl_scan.sv
rtl/core/stl_outq.sv
rtl/core/script_token_lexer.sv
bench/testbench.sv
